[sv/hex_escape_decoder_core_macros.svh]
// assertion macros for the hex escape decoder rtl, used by hexesc_emit
// expects clk_i and rst_ni in the scope of each use
`ifndef HEX_ESCAPE_DECODER_CORE_MACROS_SVH
`define HEX_ESCAPE_DECODER_CORE_MACROS_SVH

// concurrent check, disabled while reset is asserted
`define HEXESC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// concurrent check that also holds during reset
`define HEXESC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[sv/hexesc_pkg.sv]
// shared types, character constants and hex helpers for the hex escape decoder
// no dependencies
package hexesc_pkg;

  // scanner modes
  localparam logic [1:0] ModeText  = 2'd0;
  localparam logic [1:0] ModeBsl   = 2'd1;
  localparam logic [1:0] ModeEx    = 2'd2;
  localparam logic [1:0] ModeFirst = 2'd3;

  // characters
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;

  // maximum bytes produced by one transaction
  localparam int unsigned MaxRun = 4;
  localparam int unsigned RunIdxW = $clog2(MaxRun);

  // one run of result bytes handed from scanner to emitter
  typedef struct packed {
    logic [MaxRun-1:0][7:0] bytes;
    logic [RunIdxW-1:0]     last_idx;
    logic                   term;
  } run_t;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= ChZero) && (c <= ChNine)) ||
           ((c >= ChUpA) && (c <= ChUpF)) ||
           ((c >= ChLowA) && (c <= ChLowF));
  endfunction

  // nibble value of a hex digit character, don't care otherwise
  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    if (c <= ChNine) begin
      v = c - ChZero;
    end else if (c <= ChUpF) begin
      v = c - ChUpA + 8'd10;
    end else begin
      v = c - ChLowA + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

[sv/hex_escape_decoder_core.sv]
// top level of the hex escape decoder: backslash-x hex escapes to bytes
// depends on hexesc_pkg, hexesc_scan and hexesc_emit
//
//   channel   dir  tdata          tuser          tlast
//   s_axis    in   char_in[7:0]   end_of_text    -
//   m_axis    out  byte_out[7:0]  is_terminator  last_of_run
//
// a transaction enters every cycle while each yields at most one byte and m_axis does not stall
// a transaction yielding several bytes holds the run register until its last byte is loaded for output
// a result passes through the run register and then the output register before m_axis offers it
// reset clears the scan mode to text and drops any pending run and output
// output stalls back up into s_axis_tready only once the run register is full
module hex_escape_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_in
  input  logic       s_axis_tuser_i,   // [0] end_of_text
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] byte_out
  output logic       m_axis_tuser_o,   // [0] is_terminator
  output logic       m_axis_tlast_o
);

  logic             run_valid;
  logic             run_take;
  hexesc_pkg::run_t run;

  // escape scanner
  hexesc_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .char_i      (s_axis_tdata_i),
    .eot_i       (s_axis_tuser_i),
    .run_valid_o (run_valid),
    .run_o       (run),
    .run_take_i  (run_take)
  );

  // byte serializer
  hexesc_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_valid_i (run_valid),
    .run_i       (run),
    .run_take_o  (run_take),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .byte_o      (m_axis_tdata_o),
    .term_o      (m_axis_tuser_o),
    .last_o      (m_axis_tlast_o)
  );

endmodule

[sv/hexesc_scan.sv]
// escape scanner: mode machine and run register for the hex escape decoder
// depends on hexesc_pkg
module hexesc_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         char_i,
  input  logic               eot_i,
  output logic               run_valid_o,
  output hexesc_pkg::run_t   run_o,
  input  logic               run_take_i
);

  logic [1:0]       mode_q, mode_d;
  logic [7:0]       held_q, held_d;
  logic             run_valid_q, run_valid_d;
  hexesc_pkg::run_t run_q, run_d;
  logic             has_out;
  logic             accept;

  // run register frees up in the same cycle its last byte is taken
  assign in_ready_o = !run_valid_q || run_take_i;
  assign accept     = in_valid_i && in_ready_o;

  // next mode, held digit and result run for the incoming character
  always_comb begin
    mode_d        = mode_q;
    held_d        = held_q;
    has_out       = 1'b1;
    run_d         = '0;
    run_d.term    = 1'b0;
    if (eot_i) begin
      mode_d = hexesc_pkg::ModeText;
      held_d = '0;
      run_d.term = 1'b1;
      unique case (mode_q)
        hexesc_pkg::ModeBsl: begin
          run_d.bytes[0] = hexesc_pkg::ChBsl;
          run_d.last_idx = 2'd1;
        end
        hexesc_pkg::ModeEx: begin
          run_d.bytes[0] = hexesc_pkg::ChBsl;
          run_d.bytes[1] = hexesc_pkg::ChX;
          run_d.last_idx = 2'd2;
        end
        hexesc_pkg::ModeFirst: begin
          run_d.bytes[0] = hexesc_pkg::ChBsl;
          run_d.bytes[1] = hexesc_pkg::ChX;
          run_d.bytes[2] = held_q;
          run_d.last_idx = 2'd3;
        end
        default: begin
          run_d.last_idx = 2'd0;
        end
      endcase
    end else begin
      unique case (mode_q)
        hexesc_pkg::ModeText: begin
          if (char_i == hexesc_pkg::ChBsl) begin
            mode_d  = hexesc_pkg::ModeBsl;
            has_out = 1'b0;
          end else begin
            run_d.bytes[0] = char_i;
            run_d.last_idx = 2'd0;
          end
        end
        hexesc_pkg::ModeBsl: begin
          if (char_i == hexesc_pkg::ChX) begin
            mode_d  = hexesc_pkg::ModeEx;
            has_out = 1'b0;
          end else begin
            mode_d         = hexesc_pkg::ModeText;
            run_d.bytes[0] = hexesc_pkg::ChBsl;
            run_d.bytes[1] = char_i;
            run_d.last_idx = 2'd1;
          end
        end
        hexesc_pkg::ModeEx: begin
          if (hexesc_pkg::is_hex(char_i)) begin
            mode_d  = hexesc_pkg::ModeFirst;
            held_d  = char_i;
            has_out = 1'b0;
          end else begin
            mode_d         = hexesc_pkg::ModeText;
            run_d.bytes[0] = hexesc_pkg::ChBsl;
            run_d.bytes[1] = hexesc_pkg::ChX;
            run_d.bytes[2] = char_i;
            run_d.last_idx = 2'd2;
          end
        end
        default: begin
          mode_d = hexesc_pkg::ModeText;
          if (hexesc_pkg::is_hex(char_i) && hexesc_pkg::is_hex(held_q)) begin
            run_d.bytes[0] = {hexesc_pkg::hex_nib(held_q), hexesc_pkg::hex_nib(char_i)};
            run_d.last_idx = 2'd0;
          end else begin
            run_d.bytes[0] = hexesc_pkg::ChBsl;
            run_d.bytes[1] = hexesc_pkg::ChX;
            run_d.bytes[2] = held_q;
            run_d.bytes[3] = char_i;
            run_d.last_idx = 2'd3;
          end
        end
      endcase
    end
  end

  // run register valid flag
  always_comb begin
    if (accept) begin
      run_valid_d = has_out;
    end else if (run_take_i) begin
      run_valid_d = 1'b0;
    end else begin
      run_valid_d = run_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= hexesc_pkg::ModeText;
      held_q      <= '0;
      run_valid_q <= 1'b0;
    end else begin
      run_valid_q <= run_valid_d;
      if (accept) begin
        mode_q <= mode_d;
        held_q <= held_d;
      end
    end
  end

  // run payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      run_q <= run_d;
    end
  end

  assign run_valid_o = run_valid_q;
  assign run_o       = run_q;

endmodule

[sv/hexesc_emit.sv]
// run serializer and output register for the hex escape decoder
// depends on hexesc_pkg and hex_escape_decoder_core_macros.svh
`include "hex_escape_decoder_core_macros.svh"

module hexesc_emit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             run_valid_i,
  input  hexesc_pkg::run_t run_i,
  output logic             run_take_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       byte_o,
  output logic             term_o,
  output logic             last_o
);

  logic [hexesc_pkg::RunIdxW-1:0] idx_q, idx_d;
  logic                           valid_q, valid_d;
  logic [7:0]                     byte_q;
  logic                           term_q;
  logic                           last_q;
  logic                           load;
  logic                           at_last;

  // output register takes the next byte when empty or being drained
  assign load       = run_valid_i && (!valid_q || out_ready_i);
  assign at_last    = (idx_q == run_i.last_idx);
  assign run_take_o = load && at_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = at_last ? '0 : idx_q + 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= run_i.bytes[idx_q];
      term_q <= run_i.term && at_last;
      last_q <= at_last;
    end
  end

  assign out_valid_o = valid_q;
  assign byte_o      = byte_q;
  assign term_o      = term_q;
  assign last_o      = last_q;

  // serializer index stays within the pending run
  `HEXESC_ASSERT(a_idx_in_run, run_valid_i |-> (idx_q <= run_i.last_idx), "index past run end")
  // a finished run restarts the index
  `HEXESC_ASSERT(a_idx_restart, run_take_o |=> (idx_q == '0), "index not restarted after run")
  // terminator is the last byte of its run and carries zero
  `HEXESC_ASSERT(a_term_last, (valid_q && term_q) |-> (last_q && byte_q == '0), "bad terminator")
  // index is idle at zero and the output register empty while reset holds
  `HEXESC_ASSERT_ALWAYS(a_rst_idx, !rst_ni |-> (idx_q == '0 && !valid_q), "not cleared in reset")

endmodule

[tb/hex_escape_checker.sv]
// checker for the hex escape decoder: watches both stream channels,
// predicts the decoded bytes and compares them as they leave the block
// depends on hexesc_pkg for the mode codes and character constants
module hex_escape_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  input  logic       s_axis_tready_i,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_in
  input  logic       s_axis_tuser_i,   // [0] end_of_text
  input  logic       m_axis_tvalid_i,
  input  logic       m_axis_tready_i,
  input  logic [7:0] m_axis_tdata_i,   // [7:0] byte_out
  input  logic       m_axis_tuser_i,   // [0] is_terminator
  input  logic       m_axis_tlast_i,
  output int         fail_cnt_o,
  output int         pending_o,
  output int         chars_o,
  output int         bytes_o,
  output int         strings_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       term;
    logic       last;
  } out_byte_t;

  // decoded bytes still owed by the block, oldest first
  out_byte_t  expected_bytes[$];
  logic [1:0] scan_mode_q;
  logic [7:0] held_digit_q;

  // {is hex digit, nibble value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= hexesc_pkg::ChZero && c <= hexesc_pkg::ChNine) begin
      r = {1'b1, 4'(c - hexesc_pkg::ChZero)};
    end else if (c >= hexesc_pkg::ChUpA && c <= hexesc_pkg::ChUpF) begin
      r = {1'b1, 4'(c - hexesc_pkg::ChUpA + 8'd10)};
    end else if (c >= hexesc_pkg::ChLowA && c <= hexesc_pkg::ChLowF) begin
      r = {1'b1, 4'(c - hexesc_pkg::ChLowA + 8'd10)};
    end
    return r;
  endfunction

  function automatic out_byte_t plain_byte(input logic [7:0] b);
    return '{data: b, term: 1'b0, last: 1'b0};
  endfunction

  // advance the scanner by one character and queue the bytes it releases
  task automatic decode_char(input logic [7:0] c, input logic eot);
    out_byte_t  run[$];
    logic [4:0] d1;
    logic [4:0] d2;
    if (eot) begin
      // flush a partial escape, then close the string
      if (scan_mode_q != hexesc_pkg::ModeText) begin
        run.push_back(plain_byte(hexesc_pkg::ChBsl));
      end
      if (scan_mode_q == hexesc_pkg::ModeEx || scan_mode_q == hexesc_pkg::ModeFirst) begin
        run.push_back(plain_byte(hexesc_pkg::ChX));
      end
      if (scan_mode_q == hexesc_pkg::ModeFirst) begin
        run.push_back(plain_byte(held_digit_q));
      end
      run.push_back('{data: 8'h00, term: 1'b1, last: 1'b0});
      scan_mode_q  = hexesc_pkg::ModeText;
      held_digit_q = 8'h00;
    end else begin
      case (scan_mode_q)
        hexesc_pkg::ModeText: begin
          if (c == hexesc_pkg::ChBsl) scan_mode_q = hexesc_pkg::ModeBsl;
          else run.push_back(plain_byte(c));
        end
        hexesc_pkg::ModeBsl: begin
          if (c == hexesc_pkg::ChX) begin
            scan_mode_q = hexesc_pkg::ModeEx;
          end else begin
            // the second character never opens a new escape
            run.push_back(plain_byte(hexesc_pkg::ChBsl));
            run.push_back(plain_byte(c));
            scan_mode_q = hexesc_pkg::ModeText;
          end
        end
        hexesc_pkg::ModeEx: begin
          d2 = hex_digit(c);
          if (!d2[4]) begin
            run.push_back(plain_byte(hexesc_pkg::ChBsl));
            run.push_back(plain_byte(hexesc_pkg::ChX));
            run.push_back(plain_byte(c));
            scan_mode_q = hexesc_pkg::ModeText;
          end else begin
            held_digit_q = c;
            scan_mode_q  = hexesc_pkg::ModeFirst;
          end
        end
        default: begin
          d1 = hex_digit(held_digit_q);
          d2 = hex_digit(c);
          if (!d1[4] || !d2[4]) begin
            run.push_back(plain_byte(hexesc_pkg::ChBsl));
            run.push_back(plain_byte(hexesc_pkg::ChX));
            run.push_back(plain_byte(held_digit_q));
            run.push_back(plain_byte(c));
          end else begin
            run.push_back(plain_byte({d1[3:0], d2[3:0]}));
          end
          scan_mode_q = hexesc_pkg::ModeText;
        end
      endcase
    end
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) expected_bytes.push_back(run[i]);
  endtask

  task automatic report_fail(input string what, input out_byte_t exp_b);
    fail_cnt_o++;
    if (fail_cnt_o <= 10) begin
      $display("%0t hex_escape_checker: %s: expected byte %02h term %0b last %0b,",
               $realtime, what, exp_b.data, exp_b.term, exp_b.last);
      $display("  got byte %02h term %0b last %0b",
               m_axis_tdata_i, m_axis_tuser_i, m_axis_tlast_i);
    end
  endtask

  // output side is checked before the input side so a result can never
  // be matched against an expectation created at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_byte_t exp_b;
    if (!rst_ni) begin
      scan_mode_q  = hexesc_pkg::ModeText;
      held_digit_q = 8'h00;
      expected_bytes.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
      chars_o    = 0;
      bytes_o    = 0;
      strings_o  = 0;
    end else begin
      // result transaction
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        bytes_o++;
        if (m_axis_tuser_i) strings_o++;
        if (expected_bytes.size() == 0) begin
          report_fail("unexpected result", '0);
        end else begin
          exp_b = expected_bytes.pop_front();
          if (exp_b.data != m_axis_tdata_i || exp_b.term != m_axis_tuser_i ||
              exp_b.last != m_axis_tlast_i) begin
            report_fail("mismatch", exp_b);
          end
        end
      end
      // character transaction
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        chars_o++;
        decode_char(s_axis_tdata_i, s_axis_tuser_i);
      end
      pending_o = expected_bytes.size();
    end
  end

endmodule

[tb/tb_top.sv]
// testbench top for hex_escape_decoder_core: clock, reset, character
// stimulus and output back-pressure; checking lives in hex_escape_checker
// depends on hexesc_pkg, hex_escape_checker and the decoder rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 80;

  typedef enum {RxFree, RxChoppy} rx_style_e;
  typedef enum {TokPlain, TokEscape, TokBadBsl, TokBadEx, TokBadDigit, TokCut} tok_e;

  typedef struct packed {
    logic [7:0] c;
    logic       eot;
  } text_item_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       m_tlast;

  int fail_cnt;
  int pending;
  int chars_in;
  int bytes_out;
  int strings_done;

  rx_style_e  rx_style = RxChoppy;
  bit         hold_req = 1'b0;
  text_item_t text_q[$];

  always #1 clk = ~clk;

  hex_escape_decoder_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  hex_escape_checker i_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending),
    .chars_o         (chars_in),
    .bytes_o         (bytes_out),
    .strings_o       (strings_done)
  );

  // receiver: free running, choppy with a drifting stall rate, or one long hold
  initial begin
    int stall_pct;
    int tick;
    stall_pct = 30;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_style == RxFree) begin
        m_tready <= 1'b1;
      end else begin
        tick++;
        if (tick % 64 == 0) stall_pct = $urandom_range(10, 70);
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // run-away guard
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return hexesc_pkg::ChZero + 8'(v);
    if ($urandom_range(0, 1) == 1) return hexesc_pkg::ChUpA + 8'(v - 10);
    return hexesc_pkg::ChLowA + 8'(v - 10);
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c inside {[hexesc_pkg::ChZero:hexesc_pkg::ChNine],
                         [hexesc_pkg::ChUpA:hexesc_pkg::ChUpF],
                         [hexesc_pkg::ChLowA:hexesc_pkg::ChLowF]});
    return c;
  endfunction

  task automatic add_char(input logic [7:0] c, input logic eot);
    text_q.push_back('{c: c, eot: eot});
  endtask

  // one random piece of text, mostly well formed escapes and plain text
  task automatic add_token();
    int         pick;
    int         cut;
    tok_e       tok;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 28) tok = TokPlain;
    else if (pick < 58) tok = TokEscape;
    else if (pick < 67) tok = TokBadBsl;
    else if (pick < 76) tok = TokBadEx;
    else if (pick < 85) tok = TokBadDigit;
    else tok = TokCut;
    case (tok)
      TokPlain: begin
        add_char(8'($urandom_range(0, 255)), 1'b0);
      end
      TokEscape: begin
        add_char(hexesc_pkg::ChBsl, 1'b0);
        add_char(hexesc_pkg::ChX, 1'b0);
        add_char(rand_hex_char(), 1'b0);
        add_char(rand_hex_char(), 1'b0);
      end
      TokBadBsl: begin
        if ($urandom_range(0, 3) == 0) begin
          c = hexesc_pkg::ChBsl;
        end else begin
          do c = 8'($urandom_range(0, 255)); while (c == hexesc_pkg::ChX);
        end
        add_char(hexesc_pkg::ChBsl, 1'b0);
        add_char(c, 1'b0);
      end
      TokBadEx: begin
        add_char(hexesc_pkg::ChBsl, 1'b0);
        add_char(hexesc_pkg::ChX, 1'b0);
        add_char(rand_non_hex(), 1'b0);
      end
      TokBadDigit: begin
        add_char(hexesc_pkg::ChBsl, 1'b0);
        add_char(hexesc_pkg::ChX, 1'b0);
        add_char(rand_hex_char(), 1'b0);
        add_char(rand_non_hex(), 1'b0);
      end
      default: begin
        // end of string, possibly in the middle of an escape
        cut = $urandom_range(0, 3);
        if (cut >= 1) add_char(hexesc_pkg::ChBsl, 1'b0);
        if (cut >= 2) add_char(hexesc_pkg::ChX, 1'b0);
        if (cut >= 3) add_char(rand_hex_char(), 1'b0);
        add_char(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
  endtask

  // offer one character until the block takes it; entered and left at a rising edge
  task automatic send_char(input text_item_t item);
    s_tvalid <= 1'b1;
    s_tdata  <= item.c;
    s_tuser  <= item.eot;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // drain the text queue, in bursts with random gaps or back to back
  task automatic send_text(input bit with_gaps);
    int burst_left;
    burst_left = $urandom_range(1, 10);
    while (text_q.size() > 0) begin
      send_char(text_q.pop_front());
      burst_left--;
      if (with_gaps && burst_left == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 10);
      end
    end
  endtask

  // stop offering and wait until every expected byte has left the block
  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: character extremes, digit extremes, every malformed escape,
    // end of string in text and inside partial escapes
    add_char(8'h00, 1'b0);
    add_char(8'hFF, 1'b0);
    add_char(hexesc_pkg::ChBsl, 1'b0); add_char(hexesc_pkg::ChX, 1'b0);
    add_char(hexesc_pkg::ChZero, 1'b0);
    add_char(hexesc_pkg::ChUpF, 1'b0);
    add_char(hexesc_pkg::ChBsl, 1'b0); add_char(hexesc_pkg::ChX, 1'b0);
    add_char(hexesc_pkg::ChLowA, 1'b0);
    add_char(hexesc_pkg::ChNine, 1'b0);
    add_char(hexesc_pkg::ChBsl, 1'b0); add_char(8'h71, 1'b0);
    add_char(hexesc_pkg::ChBsl, 1'b0); add_char(hexesc_pkg::ChBsl, 1'b0);
    add_char(hexesc_pkg::ChBsl, 1'b0); add_char(hexesc_pkg::ChX, 1'b0);
    add_char(8'h67, 1'b0);
    add_char(hexesc_pkg::ChBsl, 1'b0); add_char(hexesc_pkg::ChX, 1'b0);
    add_char(hexesc_pkg::ChNine, 1'b0);
    add_char(8'h47, 1'b0);
    add_char(8'h00, 1'b1);
    add_char(hexesc_pkg::ChBsl, 1'b0); add_char(8'hFF, 1'b1);
    add_char(hexesc_pkg::ChBsl, 1'b0); add_char(hexesc_pkg::ChX, 1'b0);
    add_char(8'h5A, 1'b1);
    rx_style = RxChoppy;
    send_text(1'b1);
    drain_outputs();

    // random text with idle gaps on both sides
    while (text_q.size() < 35) add_token();
    send_text(1'b1);

    // long receiver hold while characters keep coming back to back
    hold_req = 1'b1;
    while (text_q.size() < 35) add_token();
    send_text(1'b0);
    drain_outputs();

    // a stretch with no idling on either side
    rx_style = RxFree;
    while (text_q.size() < 35) add_token();
    send_text(1'b0);

    drain_outputs();
    repeat (10) @(posedge clk);

    $display("tb_top: %0d characters sent, %0d bytes checked, %0d strings closed",
             chars_in, bytes_out, strings_done);
    $display("tb_top: escapes, malformed escapes, cut strings and long stalls seen, %0d failures",
             fail_cnt);
    if (fail_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
